/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property.
`define VLI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("vli assertion failed");

// Condition now, consequence in the next cycle.
`define VLI_ASSERT_NEXT(lbl, clk, rst, cond, nxt) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("vli assertion failed");

`endif

/* rtl/vli_pkg.sv */
// Shared constants for the vertical level interpolator.
`default_nettype none

package vli_pkg;

   localparam int MAX_LEVELS_DEFAULT = 64;

   localparam logic [1:0] OP_LOAD_HEIGHT = 2'd0;
   localparam logic [1:0] OP_LOAD_SAMPLE = 2'd1;
   localparam logic [1:0] OP_INTERP      = 2'd2;

   localparam logic [1:0] ST_VALID   = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_ERROR   = 2'd2;

   localparam logic [2:0] CSR_MODE        = 3'd0;
   localparam logic [2:0] CSR_NUM_LEVELS  = 3'd1;
   localparam logic [2:0] CSR_MISSING     = 3'd2;
   localparam logic [2:0] CSR_BAD         = 3'd3;
   localparam logic [2:0] CSR_SURF_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_SURF_SPEED  = 3'd5;

   localparam logic [6:0]         NUM_LEVELS_RESET  = 7'd2;
   localparam logic signed [31:0] SURF_HEIGHT_RESET = 32'sd65536;

   localparam logic [29:0]        LN2_Q30       = 30'd744261118;
   localparam logic signed [63:0] T_LIMIT       = 64'sd536870912;
   localparam logic signed [63:0] SPEED_DIVISOR = 64'sd1000;
   // ceil(2^42 / 1000): exact quotient by 1000 for magnitudes below 2^32
   localparam logic [33:0]        SPEED_RECIP   = 34'd4398046512;

endpackage

`default_nettype wire

/* rtl/vertical_level_interpolator.sv */
// Top level: column stores, nearest-level search and fixed-point interpolation sequencer.
//
//   channel   ports                                         handshake
//   request   req_operation, req_level_index, req_value     start & !busy
//   response  rsp_out_value, rsp_status                     rsp_valid strobe, one cycle
//   config    csr_index, csr_write_data                     csr_write_enable
//
// Loads leave busy low. An interpolation makes two passes over the height memory, one
// read per cycle, then in linear mode runs a 64-step radix-2 divider; power mode instead
// scales the surface speed by a reciprocal multiply, runs three logarithms and two
// 64-step divisions.
// Reset is synchronous; the stores hold no valid bits and need no clearing pass.
// The response cannot be stalled; it shows in the cycle busy falls.
`default_nettype none

module vertical_level_interpolator #(
   parameter int MAX_LEVELS = vli_pkg::MAX_LEVELS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_operation,
   input  wire logic [5:0]         req_level_index,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_out_value,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_write_data
);
   import vli_pkg::*;

   localparam int IW = $clog2(MAX_LEVELS);
   localparam int CW = $clog2(MAX_LEVELS + 1);

   typedef enum logic [23:0] {
      S_IDLE  = 24'h000001,
      S_SRCH  = 24'h000002,
      S_FETCH = 24'h000004,
      S_CHECK = 24'h000008,
      S_DIV   = 24'h000010,
      S_LNORM = 24'h000020,
      S_LSQ   = 24'h000040,
      S_LSC   = 24'h000080,
      S_LRND  = 24'h000100,
      S_LMUL  = 24'h000200,
      S_LFIN  = 24'h000400,
      S_PADJ  = 24'h000800,
      S_PL1   = 24'h001000,
      S_PL2   = 24'h002000,
      S_PL3   = 24'h004000,
      S_PM1   = 24'h008000,
      S_PM2   = 24'h010000,
      S_PDV   = 24'h020000,
      S_PLOGA = 24'h040000,
      S_PM3   = 24'h080000,
      S_PDV2  = 24'h100000,
      S_PFIN  = 24'h200000,
      S_DONE  = 24'h400000,
      S_PREC  = 24'h800000
   } state_type;

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // configuration
   logic               mode_ff;
   logic [6:0]         nl_ff;
   logic signed [31:0] miss_ff, bad_ff, h0_ff, u0cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         nl_ff    <= NUM_LEVELS_RESET;
         miss_ff  <= '0;
         bad_ff   <= '0;
         h0_ff    <= SURF_HEIGHT_RESET;
         u0cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:        mode_ff  <= csr_write_data[0];
            CSR_NUM_LEVELS:  nl_ff    <= csr_write_data[6:0];
            CSR_MISSING:     miss_ff  <= csr_write_data;
            CSR_BAD:         bad_ff   <= csr_write_data;
            CSR_SURF_HEIGHT: h0_ff    <= csr_write_data;
            CSR_SURF_SPEED:  u0cfg_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0]      cnt_ff, cnt_in, n_ff, n_in;
   logic               rdv_ff, rdv_in, pass_ff, pass_in, first_ff, first_in;
   logic [IW-1:0]      rdi_ff, rdi_in, ci_ff, ci_in, ni_ff, ni_in;
   logic [32:0]        best_ff, best_in;
   logic signed [31:0] tgt_ff, tgt_in, hc_ff, hc_in, hn_ff, hn_in, sc_ff, sc_in, sn_ff, sn_in;
   logic signed [32:0] u0_ff, u0_in;
   logic [6:0]         step_ff, step_in;
   logic [63:0]        rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic               dneg_ff, dneg_in;
   logic [30:0]        ln_m_ff, ln_m_in;
   logic [4:0]         ln_p_ff, ln_p_in;
   logic [29:0]        ln_f_ff, ln_f_in;
   logic signed [39:0] ln_a_ff, ln_a_in;
   logic [59:0]        ln_b_ff, ln_b_in;
   logic signed [31:0] ln_q_ff, ln_q_in, l0_ff, l0_in, l1_ff, l1_in, lt_ff, lt_in;
   logic signed [63:0] acc_ff, acc_in, den_ff, den_in;
   logic signed [66:0] prod_ff, prod_in;
   logic signed [33:0] sum_ff, sum_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0]         st_ff, st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   // column stores; loads only land while idle, so the reads of a search never overlap a write
   logic signed [31:0] hgt_mem [MAX_LEVELS];
   logic signed [31:0] smp_mem [MAX_LEVELS];
   logic signed [31:0] hq_ff, sq_ff;
   logic [IW-1:0]      rd_addr, wr_addr;
   logic               accept, in_range, wr_h, wr_s, issue;

   assign accept   = start && !busy;
   assign in_range = 32'(req_level_index) < 32'(MAX_LEVELS);
   assign wr_addr  = IW'(req_level_index);
   assign wr_h     = accept && in_range && req_operation == OP_LOAD_HEIGHT;
   assign wr_s     = accept && in_range && req_operation == OP_LOAD_SAMPLE;
   assign issue    = state_ff == S_SRCH && cnt_ff < n_ff;

   always_comb begin
      if (state_ff == S_SRCH) rd_addr = cnt_ff[IW-1:0];
      else if (state_ff == S_FETCH && step_ff == 7'd0) rd_addr = ci_ff;
      else rd_addr = ni_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_h) hgt_mem[wr_addr] <= req_value;
      if (wr_s) smp_mem[wr_addr] <= req_value;
      hq_ff <= hgt_mem[rd_addr];
      sq_ff <= smp_mem[rd_addr];
   end

   // datapath helpers
   logic signed [32:0] dist_diff;
   logic [32:0]        dist_mag;
   logic signed [63:0] div_q;
   logic [64:0]        div_trial;
   logic               div_ge;
   logic [61:0]        ln_sq;
   logic [31:0]        ln_s2;
   logic signed [5:0]  ln_pe;
   logic signed [39:0] ln_l30;
   logic [39:0]        ln_mag;
   logic [26:0]        ln_r;
   logic signed [30:0] t_sat;
   logic [66:0]        lp_mag;
   logic [50:0]        lp_r;
   logic signed [67:0] lin_sum;
   logic               flag_sc, flag_sn, opposed, shrink;
   logic signed [32:0] u0_neg;
   logic [35:0]        u0_x10;
   logic signed [63:0] loga, den_v;
   logic signed [32:0] mul_a;
   logic signed [33:0] mul_b;
   logic [31:0]        n_clamp;

   assign dist_diff = 33'(hq_ff) - 33'(tgt_ff);
   assign dist_mag  = dist_diff[32] ? 33'(-dist_diff) : 33'(dist_diff);
   assign div_q     = dneg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign div_trial = {rem_ff, quo_ff[63]};
   assign div_ge    = div_trial >= {1'b0, dvs_ff};
   assign ln_sq     = ln_m_ff * ln_m_ff;
   assign ln_s2     = ln_sq[61:30];
   assign ln_pe     = $signed({1'b0, ln_p_ff}) - 6'sd16;
   assign ln_l30    = ln_a_ff + $signed({10'd0, ln_b_ff[59:30]});
   assign ln_mag    = ln_l30[39] ? 40'(-ln_l30) : 40'(ln_l30);
   assign ln_r      = 27'((ln_mag + 40'd8192) >> 14);
   assign t_sat     = (div_q > T_LIMIT) ? 31'(T_LIMIT) :
                      (div_q < -T_LIMIT) ? 31'(-T_LIMIT) : 31'(div_q);
   assign lp_mag    = prod_ff[66] ? 67'(-prod_ff) : 67'(prod_ff);
   assign lp_r      = 51'((lp_mag + 67'd32768) >> 16);
   assign lin_sum   = 68'(sn_ff) + (prod_ff[66] ? -$signed({17'd0, lp_r})
                                                 : $signed({17'd0, lp_r}));
   assign flag_sc   = sc_ff == miss_ff || sc_ff == bad_ff;
   assign flag_sn   = sn_ff == miss_ff || sn_ff == bad_ff;
   assign opposed   = (sc_ff < 0 && u0cfg_ff > 0) || (sc_ff > 0 && u0cfg_ff < 0);
   assign u0_neg    = opposed ? -33'(u0cfg_ff) : 33'(u0cfg_ff);
   assign u0_x10    = (36'(abs64(64'(u0_ff))) << 3) + (36'(abs64(64'(u0_ff))) << 1);
   assign shrink    = u0_x10 > 36'(abs64(64'(sc_ff)));
   assign loga      = div_q;
   assign den_v     = loga + 64'(l1_ff);
   assign n_clamp   = (nl_ff == 7'd0) ? 32'd1 :
                      (32'(nl_ff) > 32'(MAX_LEVELS)) ? 32'(MAX_LEVELS) : 32'(nl_ff);

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_LMUL: begin
            mul_a = 33'(t_sat);
            mul_b = 34'(sc_ff) - 34'(sn_ff);
         end
         S_PREC: begin
            mul_a = 33'(abs64(64'(sc_ff)));
            mul_b = $signed(SPEED_RECIP);
         end
         S_PM1: begin
            mul_a = 33'(sc_ff);
            mul_b = 34'(l0_ff);
         end
         S_PM2: begin
            mul_a = u0_ff;
            mul_b = 34'(l1_ff);
         end
         S_PM3: begin
            mul_a = 33'(sc_ff);
            mul_b = sum_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;   ret_in   = ret_ff;    cnt_in   = cnt_ff;   n_in    = n_ff;
      rdv_in   = 1'b0;       rdi_in   = rdi_ff;    pass_in  = pass_ff;  first_in = first_ff;
      ci_in    = ci_ff;      ni_in    = ni_ff;     best_in  = best_ff;  tgt_in  = tgt_ff;
      hc_in    = hc_ff;      hn_in    = hn_ff;     sc_in    = sc_ff;    sn_in   = sn_ff;
      u0_in    = u0_ff;      step_in  = step_ff;   rem_in   = rem_ff;   quo_in  = quo_ff;
      dvs_in   = dvs_ff;     dneg_in  = dneg_ff;   ln_m_in  = ln_m_ff;  ln_p_in = ln_p_ff;
      ln_f_in  = ln_f_ff;    ln_a_in  = ln_a_ff;   ln_b_in  = ln_b_ff;  ln_q_in = ln_q_ff;
      l0_in    = l0_ff;      l1_in    = l1_ff;     lt_in    = lt_ff;    acc_in  = acc_ff;
      den_in   = den_ff;     sum_in   = sum_ff;    res_in   = res_ff;   st_in   = st_ff;
      prod_in  = prod_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_operation == OP_INTERP) begin
               tgt_in   = req_value;
               n_in     = CW'(n_clamp);
               cnt_in   = '0;
               pass_in  = 1'b0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            rdv_in = issue;
            rdi_in = cnt_ff[IW-1:0];
            if (issue) cnt_in = cnt_ff + 1'b1;
            if (rdv_ff) begin
               if (!pass_ff) begin
                  if (rdi_ff == '0 || dist_mag < best_ff) begin
                     best_in = dist_mag;
                     ci_in   = rdi_ff;
                  end
               end else if (rdi_ff != ci_ff && (first_ff || dist_mag < best_ff)) begin
                  best_in  = dist_mag;
                  ni_in    = rdi_ff;
                  first_in = 1'b0;
               end
            end
            if (!issue && !rdv_ff) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  cnt_in   = '0;
                  first_in = 1'b1;
                  ni_in    = '0;
               end else begin
                  step_in  = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 7'd1) begin
               hc_in = hq_ff;
               sc_in = sq_ff;
            end else if (step_ff == 7'd2) begin
               hn_in    = hq_ff;
               sn_in    = sq_ff;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            st_in = ST_VALID;
            if (!mode_ff) begin
               if (flag_sc || flag_sn) begin
                  st_in    = ST_MISSING;
                  state_in = S_DONE;
               end else if (hc_ff == hn_ff) begin
                  st_in    = ST_ERROR;
                  state_in = S_DONE;
               end else begin
                  quo_in   = abs64((64'(tgt_ff) - 64'(hn_ff)) <<< 16);
                  dvs_in   = abs64(64'(hc_ff) - 64'(hn_ff));
                  dneg_in  = (tgt_ff < hn_ff) != (hc_ff < hn_ff);
                  rem_in   = '0;
                  step_in  = '0;
                  ret_in   = S_LMUL;
                  state_in = S_DIV;
               end
            end else begin
               if (flag_sc) begin
                  st_in    = ST_MISSING;
                  state_in = S_DONE;
               end else if (sc_ff == 32'sd0) begin
                  res_in   = '0;
                  state_in = S_DONE;
               end else begin
                  u0_in    = u0_neg;
                  state_in = S_PREC;
               end
            end
         end
         S_PREC: begin
            // |u1| / 1000 by reciprocal multiply, quotient in bits 63:42
            prod_in  = mul_a * mul_b;
            state_in = S_PADJ;
         end
         S_DIV: begin
            rem_in  = div_ge ? 64'(div_trial - {1'b0, dvs_ff}) : div_trial[63:0];
            quo_in  = {quo_ff[62:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == 7'd63) state_in = ret_ff;
         end
         S_LMUL: begin
            prod_in  = mul_a * mul_b;
            state_in = S_LFIN;
         end
         S_LFIN: begin
            if (lin_sum > 68'sd2147483647) res_in = 32'sh7fffffff;
            else if (lin_sum < -68'sd2147483648) res_in = 32'sh80000000;
            else res_in = 32'(lin_sum);
            state_in = S_DONE;
         end
         S_PADJ: begin
            if (shrink) u0_in = sc_ff[31] ? -33'(prod_ff[63:42]) : 33'(prod_ff[63:42]);
            if (h0_ff <= 0 || hc_ff <= 0 || tgt_ff <= 0) begin
               st_in    = ST_ERROR;
               state_in = S_DONE;
            end else begin
               ln_m_in  = h0_ff[30:0];
               ln_p_in  = 5'd30;
               ret_in   = S_PL1;
               state_in = S_LNORM;
            end
         end
         S_LNORM: begin
            // shift up until the leading one sits at bit 30
            if (ln_m_ff[30]) begin
               step_in  = '0;
               ln_f_in  = '0;
               state_in = S_LSQ;
            end else begin
               ln_m_in = {ln_m_ff[29:0], 1'b0};
               ln_p_in = ln_p_ff - 1'b1;
            end
         end
         S_LSQ: begin
            ln_m_in = ln_s2[31] ? ln_s2[31:1] : ln_s2[30:0];
            ln_f_in = {ln_f_ff[28:0], ln_s2[31]};
            step_in = step_ff + 1'b1;
            if (step_ff == 7'd29) state_in = S_LSC;
         end
         S_LSC: begin
            ln_a_in  = ln_pe * $signed({1'b0, LN2_Q30});
            ln_b_in  = ln_f_ff * LN2_Q30;
            state_in = S_LRND;
         end
         S_LRND: begin
            ln_q_in  = ln_l30[39] ? -$signed({5'd0, ln_r}) : $signed({5'd0, ln_r});
            state_in = ret_ff;
         end
         S_PL1: begin
            l0_in    = ln_q_ff;
            ln_m_in  = hc_ff[30:0];
            ln_p_in  = 5'd30;
            ret_in   = S_PL2;
            state_in = S_LNORM;
         end
         S_PL2: begin
            l1_in    = ln_q_ff;
            ln_m_in  = tgt_ff[30:0];
            ln_p_in  = 5'd30;
            ret_in   = S_PL3;
            state_in = S_LNORM;
         end
         S_PL3: begin
            lt_in    = ln_q_ff;
            state_in = S_PM1;
         end
         S_PM1: begin
            prod_in  = mul_a * mul_b;
            state_in = S_PM2;
         end
         S_PM2: begin
            acc_in   = 64'(prod_ff);
            prod_in  = mul_a * mul_b;
            state_in = S_PDV;
         end
         S_PDV: begin
            quo_in   = abs64(acc_ff - 64'(prod_ff));
            dvs_in   = abs64(64'(u0_ff) - 64'(sc_ff));
            dneg_in  = ((acc_ff - 64'(prod_ff)) < 0) != (64'(u0_ff) < 64'(sc_ff));
            rem_in   = '0;
            step_in  = '0;
            ret_in   = S_PLOGA;
            state_in = S_DIV;
         end
         S_PLOGA: begin
            if (loga < 0 || den_v == 64'sd0) begin
               st_in    = ST_ERROR;
               state_in = S_DONE;
            end else begin
               sum_in   = 34'(loga + 64'(lt_ff));
               den_in   = den_v;
               state_in = S_PM3;
            end
         end
         S_PM3: begin
            prod_in  = mul_a * mul_b;
            state_in = S_PDV2;
         end
         S_PDV2: begin
            quo_in   = abs64(64'(prod_ff));
            dvs_in   = abs64(den_ff);
            dneg_in  = prod_ff[66] != den_ff[63];
            rem_in   = '0;
            step_in  = '0;
            ret_in   = S_PFIN;
            state_in = S_DIV;
         end
         S_PFIN: begin
            if (div_q > 64'sd2147483647) res_in = 32'sh7fffffff;
            else if (div_q < -64'sd2147483648) res_in = 32'sh80000000;
            else res_in = 32'(div_q);
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = (st_ff != ST_VALID) ? miss_ff : res_ff;
            rsp_status_in = st_ff;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;   n_ff    <= n_in;     rdi_ff   <= rdi_in;   pass_ff <= pass_in;
      first_ff <= first_in; ci_ff   <= ci_in;    ni_ff    <= ni_in;    best_ff <= best_in;
      tgt_ff   <= tgt_in;   hc_ff   <= hc_in;    hn_ff    <= hn_in;    sc_ff   <= sc_in;
      sn_ff    <= sn_in;    u0_ff   <= u0_in;    step_ff  <= step_in;  rem_ff  <= rem_in;
      quo_ff   <= quo_in;   dvs_ff  <= dvs_in;   dneg_ff  <= dneg_in;  ln_m_ff <= ln_m_in;
      ln_p_ff  <= ln_p_in;  ln_f_ff <= ln_f_in;  ln_a_ff  <= ln_a_in;  ln_b_ff <= ln_b_in;
      ln_q_ff  <= ln_q_in;  l0_ff   <= l0_in;    l1_ff    <= l1_in;    lt_ff   <= lt_in;
      acc_ff   <= acc_in;   den_ff  <= den_in;   sum_ff   <= sum_in;   res_ff  <= res_in;
      st_ff    <= st_in;    prod_ff <= prod_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

/* rtl/vli_checker.sv */
// Port-level checker for the vertical level interpolator, with its bind.
`default_nettype none
`include "assert_macros.svh"

module vli_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_operation,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status
);
   import vli_pkg::*;

   `VLI_ASSERT_NEXT(a_interp_busy, clock, reset, start && !busy && req_operation == OP_INTERP, busy)
   `VLI_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `VLI_ASSERT(a_rsp_on_fall, clock, reset, rsp_valid |-> $fell(busy))
   `VLI_ASSERT(a_fall_gives_rsp, clock, reset, $fell(busy) |-> rsp_valid)
   `VLI_ASSERT(a_status_code, clock, reset, rsp_valid |-> (rsp_status == ST_VALID || rsp_status == ST_MISSING || rsp_status == ST_ERROR))

endmodule

bind vertical_level_interpolator vli_checker u_vli_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status)
);

`default_nettype wire
